>>> hdl/itoa_pkg.sv
// Shared types, constants and helpers for the integer to ASCII numeral block.
package itoa_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_OCT = 2'd3
  } radix_t;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_ONE   = 7'h31;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic to_bits;
    logic emit_sign;
    logic emit;
  } itoa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic decimal;
    logic binary;
    logic negative;
    logic dabble_last;
    logic skip_done;
    logic out_free;
    logic emit_last;
  } itoa_stat_t;

  // decimal digits needed for any bits-wide unsigned value (elaboration only)
  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int n;
    v = (64'd1 << bits) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        n = n + 1;
        v = v / 10;
      end
    end
    return (n < 1) ? 1 : n;
  endfunction

  // upper-case digit character for a 0..15 digit
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) c = CHAR_ZERO + {3'd0, d};
    else c = CHAR_A + {3'd0, d} - 7'd10;
    return c;
  endfunction

endpackage

>>> hdl/itoa_channels.sv
// Request channels: input value, output characters, radix configuration.
interface itoa_value_if #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itoa_text_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last_char;
  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface

interface itoa_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] output_radix;
  modport source (output valid, output output_radix, input ready);
  modport sink (input valid, input output_radix, output ready);
endinterface

>>> hdl/itoa_datapath.sv
// Datapath: radix register, digit shift register, binary to BCD, output register.
module itoa_datapath #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_BITS-1:0]  in_value,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_radix,
  input  logic                   out_ready,
  input  itoa_pkg::itoa_cmd_t    cmd,
  output itoa_pkg::itoa_stat_t   stat,
  output logic                   out_valid,
  output logic [6:0]             out_char,
  output logic                   out_last
);
  import itoa_pkg::*;

  localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
  localparam int NIB_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int W_BITS     = 4 * DEC_DIGITS;
  localparam int HEX_PAD    = W_BITS - 4 * NIB_DIGITS;
  localparam int OCT_PAD    = W_BITS - 3 * OCT_DIGITS;
  localparam int CNT_W      = $clog2(4 * NIB_DIGITS + 1);
  localparam int DCNT_W     = $clog2(VALUE_BITS + 1);

  radix_t                  radix;
  logic [W_BITS-1:0]       work;
  logic [VALUE_BITS-1:0]   mag;
  logic                    negative;
  logic [DCNT_W-1:0]       dcnt;
  logic [CNT_W-1:0]        cnt;
  logic                    space_pend;

  logic [3:0]              top4;
  logic [2:0]              top3;
  logic [W_BITS-1:0]       work_adj;
  logic [W_BITS-1:0]       work_skip;
  logic [W_BITS-1:0]       work_emit;
  logic [6:0]              digit;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    top_nonzero;
  logic                    in_neg;

  assign top4   = work[W_BITS-1 -: 4];
  assign top3   = work[W_BITS-1 -: 3];
  assign cnt_m1 = cnt - CNT_W'(1);
  assign in_neg = in_value[VALUE_BITS-1];

  // BCD digit correction before each shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (work[4*i +: 4] >= 4'd5) work_adj[4*i +: 4] = work[4*i +: 4] + 4'd3;
      else work_adj[4*i +: 4] = work[4*i +: 4];
    end
  end

  always_comb begin
    work_skip = (radix == RADIX_OCT) ? (work << 3) : (work << 4);
    case (radix)
      RADIX_BIN: work_emit = work << 1;
      RADIX_OCT: work_emit = work << 3;
      default:   work_emit = work << 4;
    endcase
    case (radix)
      RADIX_BIN: digit = work[W_BITS-1] ? CHAR_ONE : CHAR_ZERO;
      RADIX_OCT: digit = digit_char({1'b0, top3});
      default:   digit = digit_char(top4);
    endcase
    top_nonzero = (radix == RADIX_OCT) ? (top3 != 3'd0) : (top4 != 4'd0);
  end

  always_comb begin
    stat.decimal     = (radix == RADIX_DEC);
    stat.binary      = (radix == RADIX_BIN);
    stat.negative    = negative;
    stat.dabble_last = (dcnt == DCNT_W'(1));
    stat.skip_done   = top_nonzero || (cnt == CNT_W'(1));
    stat.out_free    = !out_valid || out_ready;
    stat.emit_last   = !space_pend && (cnt == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_DEC;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) radix <= radix_t'(cfg_radix);
      if (cmd.emit || cmd.emit_sign) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end

    if (cmd.load) begin
      space_pend <= 1'b0;
      dcnt       <= DCNT_W'(VALUE_BITS);
      negative   <= (radix == RADIX_DEC) && in_neg;
      mag        <= ((radix == RADIX_DEC) && in_neg) ? (~in_value + VALUE_BITS'(1)) : in_value;
      case (radix)
        RADIX_DEC: begin
          work <= '0;
          cnt  <= CNT_W'(DEC_DIGITS);
        end
        RADIX_OCT: begin
          work <= W_BITS'(in_value) << OCT_PAD;
          cnt  <= CNT_W'(OCT_DIGITS);
        end
        default: begin
          work <= W_BITS'(in_value) << HEX_PAD;
          cnt  <= CNT_W'(NIB_DIGITS);
        end
      endcase
    end

    if (cmd.dabble) begin
      work <= {work_adj[W_BITS-2:0], mag[VALUE_BITS-1]};
      mag  <= mag << 1;
      dcnt <= dcnt - DCNT_W'(1);
    end

    if (cmd.skip) begin
      work <= work_skip;
      cnt  <= cnt_m1;
    end

    // binary: count bits from here on instead of nibble groups
    if (cmd.to_bits) cnt <= cnt << 2;

    if (cmd.emit_sign) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end

    if (cmd.emit) begin
      if (space_pend) begin
        out_char   <= CHAR_SPACE;
        out_last   <= 1'b0;
        space_pend <= 1'b0;
      end else begin
        out_char   <= digit;
        out_last   <= (cnt == CNT_W'(1));
        work       <= work_emit;
        cnt        <= cnt_m1;
        space_pend <= (radix == RADIX_BIN) && (cnt_m1[1:0] == 2'd0) && (cnt_m1 != '0);
      end
    end
  end

endmodule

>>> hdl/itoa_controller.sv
// Controller: sequences load, sign, BCD conversion, zero skip and emission.
module itoa_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  itoa_pkg::itoa_stat_t stat,
  output itoa_pkg::itoa_cmd_t  cmd
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SIGN,
    S_DABBLE,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.decimal && stat.negative) state_next = S_SIGN;
        else if (stat.decimal) state_next = S_DABBLE;
        else state_next = S_SKIP;
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DABBLE;
        end
      end
      S_DABBLE: begin
        cmd.dabble = 1'b1;
        if (stat.dabble_last) state_next = S_SKIP;
      end
      S_SKIP: begin
        if (stat.skip_done) begin
          cmd.to_bits = stat.binary;
          state_next  = S_EMIT;
        end else begin
          cmd.skip = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

>>> hdl/integer_to_ascii_numeral.sv
// Top level: integer to ASCII numeral converter.
// Takes one VALUE_BITS-wide integer per request and returns its numeral one
// character per request, most significant first, last_char set on the final one.
// output_radix picks the format: signed decimal (leading minus, most negative
// value printed in full), binary in space-separated groups of four with the
// first group zero-padded, upper-case hex, or octal; no leading zeros, zero
// prints as "0" (or "0000" in binary). Non-decimal radices print the raw bit
// pattern. One value is in flight at a time. Each value passes through load
// and setup, then in decimal a leading minus sign if negative and a
// bit-serial shift-and-add-3 BCD conversion, then a skip of leading zero
// digits, then emission at one character per cycle while the sink is ready.
// The character output is registered, so the next value is accepted while
// the final character still waits. Nothing is accepted during reset.
// Configuration writes are taken whenever out of reset and must only be
// issued while no conversion is in progress.
module integer_to_ascii_numeral #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  itoa_value_if.sink   value_ch,
  itoa_text_if.source  text_ch,
  itoa_cfg_if.sink     cfg_ch
);
  import itoa_pkg::*;

  itoa_cmd_t  cmd;
  itoa_stat_t stat;
  logic       cfg_write;

  // radix register is two bits wide; writes never stall outside reset
  assign cfg_ch.ready = !rst;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  itoa_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (value_ch.valid),
    .in_ready (value_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itoa_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_value  (value_ch.value),
    .cfg_write (cfg_write),
    .cfg_radix (cfg_ch.output_radix),
    .out_ready (text_ch.ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (text_ch.valid),
    .out_char  (text_ch.text_char),
    .out_last  (text_ch.last_char)
  );

endmodule
